### rtl/fwdo_pkg.sv
package fwdo_pkg;

  // Default sizing, overridable on the top level
  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;

  // Fixed port field widths
  localparam int OP_W   = 2;
  localparam int TAG_W  = 16;
  localparam int TIME_W = 63;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    push_wr;
    logic    set_status;
    status_t status;
    logic    scan_init;
    logic    scan_step;
    logic    pick;
    logic    shift_step;
    logic    count_dec;
    logic    resp_load;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic walk_done;
  } dp_stat_t;

endpackage

### rtl/fwdo_ctrl.sv
module fwdo_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  fwdo_pkg::dp_stat_t  stat,
  output fwdo_pkg::ctl_cmd_t  cmd
);
  import fwdo_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (stat.op)
          OP_POP, OP_PEEK: state_nxt = stat.empty ? S_RESP : S_SCAN;
          default:         state_nxt = S_RESP;
        endcase
      end
      S_SCAN: begin
        if (stat.walk_done) state_nxt = S_PICK;
      end
      S_PICK: begin
        state_nxt = (stat.op == OP_POP) ? S_SHIFT : S_RESP;
      end
      S_SHIFT: begin
        if (stat.walk_done) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands and output valid
  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        cmd.status     = STAT_OK;
        case (stat.op)
          OP_PUSH: begin
            if (stat.full) cmd.status = STAT_FULL;
            else           cmd.push_wr = 1'b1;
          end
          OP_POP, OP_PEEK: begin
            if (stat.empty) cmd.status = STAT_EMPTY;
            else            cmd.scan_init = 1'b1;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.count_dec  = stat.walk_done;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.resp_load = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/fwdo_dp.sv
module fwdo_dp #(
  parameter int QUEUE_DEPTH = fwdo_pkg::DEPTH_DEF,
  parameter int TAG_BITS    = fwdo_pkg::TAG_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fwdo_pkg::OP_W-1:0]   in_opcode,
  input  logic [fwdo_pkg::TAG_W-1:0]  in_tag,
  input  logic [fwdo_pkg::TIME_W-1:0] in_deadline,
  input  logic [fwdo_pkg::TIME_W-1:0] in_now,
  input  fwdo_pkg::ctl_cmd_t          cmd,
  output fwdo_pkg::dp_stat_t          stat,
  output logic [fwdo_pkg::STAT_W-1:0] out_status,
  output logic [fwdo_pkg::TAG_W-1:0]  out_head_tag,
  output logic [fwdo_pkg::TIME_W-1:0] out_head_deadline,
  output logic                        out_expired,
  output logic [fwdo_pkg::OCC_W-1:0]  out_occupancy
);
  import fwdo_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TAG_BITS + TIME_W;

  // Entry memory: tag above deadline
  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rd_data_r;

  // Latched item
  op_t               op_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [TIME_W-1:0] dl_r;
  logic [TIME_W-1:0] now_r;

  // Queue and walk control
  logic [CW-1:0] count_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] lag_r;
  logic          vld_r;
  status_t       status_r;
  logic          hit_r;

  // Scan results
  logic [TIME_W-1:0]   min_dl_r;
  logic [TAG_BITS-1:0] min_tag_r;
  logic [AW-1:0]       min_idx_r;
  logic [TIME_W-1:0]   old_dl_r;
  logic [TAG_BITS-1:0] old_tag_r;
  logic [TIME_W-1:0]   res_dl_r;
  logic [TAG_BITS-1:0] res_tag_r;
  logic                exp_r;

  // Output register
  logic [STAT_W-1:0] out_status_r;
  logic [TAG_W-1:0]  out_head_tag_r;
  logic [TIME_W-1:0] out_head_deadline_r;
  logic              out_expired_r;
  logic [OCC_W-1:0]  out_occupancy_r;

  logic                iss;
  logic [AW-1:0]       rd_addr;
  logic [TAG_BITS-1:0] rd_tag;
  logic [TIME_W-1:0]   rd_dl;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;
  logic                take_min;
  logic                pick_exp;
  logic [AW-1:0]       pick_idx;

  // Walk pointer issues one memory read per cycle while below the count
  assign iss     = (cnt_r < count_r);
  assign rd_addr = cnt_r[AW-1:0];
  assign rd_tag  = rd_data_r[EW-1:TIME_W];
  assign rd_dl   = rd_data_r[TIME_W-1:0];

  // Write for push at the tail, or move an entry down one slot on compaction
  assign wr_en   = cmd.push_wr || (cmd.shift_step && vld_r);
  assign wr_addr = cmd.push_wr ? count_r[AW-1:0] : (lag_r - AW'(1));
  assign wr_data = cmd.push_wr ? {tag_r, dl_r} : rd_data_r;

  // Strictly smaller deadline replaces the minimum, so earliest wins ties
  assign take_min = (lag_r == '0) || (rd_dl < min_dl_r);
  assign pick_exp = (min_dl_r < now_r);
  assign pick_idx = pick_exp ? min_idx_r : '0;

  assign stat.op        = op_r;
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r >= CW'(QUEUE_DEPTH));
  assign stat.walk_done = !iss && !vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      vld_r   <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      if (cmd.push_wr)        count_r <= count_r + CW'(1);
      else if (cmd.count_dec) count_r <= count_r - CW'(1);
      if (cmd.scan_step || cmd.shift_step) vld_r <= iss;
      else                                 vld_r <= 1'b0;
      if (cmd.load)      hit_r <= 1'b0;
      else if (cmd.pick) hit_r <= 1'b1;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_opcode);
      tag_r <= TAG_BITS'(in_tag);
      dl_r  <= in_deadline;
      now_r <= in_now;
    end
    if (cmd.set_status) status_r <= cmd.status;
  end

  // Advance the walk pointer and track the minimum
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cnt_r <= '0;
    end else if (cmd.pick) begin
      cnt_r <= CW'(pick_idx) + CW'(1);
    end else if ((cmd.scan_step || cmd.shift_step) && iss) begin
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.scan_step || cmd.shift_step) lag_r <= cnt_r[AW-1:0];

    if (cmd.scan_step && vld_r) begin
      if (take_min) begin
        min_dl_r  <= rd_dl;
        min_tag_r <= rd_tag;
        min_idx_r <= lag_r;
      end
      if (lag_r == '0) begin
        old_dl_r  <= rd_dl;
        old_tag_r <= rd_tag;
      end
    end

    if (cmd.pick) begin
      exp_r     <= pick_exp;
      res_dl_r  <= pick_exp ? min_dl_r  : old_dl_r;
      res_tag_r <= pick_exp ? min_tag_r : old_tag_r;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_status_r        <= status_r;
      out_head_tag_r      <= hit_r ? TAG_W'(res_tag_r) : '0;
      out_head_deadline_r <= hit_r ? res_dl_r : '0;
      out_expired_r       <= hit_r && exp_r;
      out_occupancy_r     <= OCC_W'(count_r);
    end
  end

  assign out_status        = out_status_r;
  assign out_head_tag      = out_head_tag_r;
  assign out_head_deadline = out_head_deadline_r;
  assign out_expired       = out_expired_r;
  assign out_occupancy     = out_occupancy_r;

endmodule

### rtl/fifo_with_deadline_override_top.sv
// Deadline-aware queue of tagged entries.
// Input channel (in_valid / in_stall): opcode push, pop or peek, with a tag,
// a deadline and the current time. Result channel (out_valid / out_stall):
// status, head tag, head deadline, expired flag and occupancy, one per item.
// Pop and peek return the entry with the smallest deadline when that deadline
// is below the current time (earliest pushed wins ties), else the oldest one.
// One item is in work at a time. Push, empty pop/peek and unused opcodes go
// from decode straight to the result; pop and peek first scan every held
// entry for the minimum, and pop then shifts the entries above the chosen
// slot down. The entry memory has a single read port, walked one entry per
// cycle for the minimum search and again for compaction after a pop.
// A finished result waits in the output register while the next item is
// taken in; a stalled receiver holds that register, and the following item
// then waits for it with the input stalled. Reset empties the queue and
// clears the result valid; entry contents are never cleared since only slots
// below the count are read.
module fifo_with_deadline_override_top #(
  parameter int QUEUE_DEPTH = fwdo_pkg::DEPTH_DEF,
  parameter int TAG_BITS    = fwdo_pkg::TAG_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fwdo_pkg::OP_W-1:0]   in_opcode,
  input  logic [fwdo_pkg::TAG_W-1:0]  in_tag,
  input  logic [fwdo_pkg::TIME_W-1:0] in_deadline,
  input  logic [fwdo_pkg::TIME_W-1:0] in_now,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fwdo_pkg::STAT_W-1:0] out_status,
  output logic [fwdo_pkg::TAG_W-1:0]  out_head_tag,
  output logic [fwdo_pkg::TIME_W-1:0] out_head_deadline,
  output logic                        out_expired,
  output logic [fwdo_pkg::OCC_W-1:0]  out_occupancy
);
  import fwdo_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  fwdo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fwdo_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_opcode),
    .in_tag            (in_tag),
    .in_deadline       (in_deadline),
    .in_now            (in_now),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_status),
    .out_head_tag      (out_head_tag),
    .out_head_deadline (out_head_deadline),
    .out_expired       (out_expired),
    .out_occupancy     (out_occupancy)
  );

endmodule

### rtl/fwdo_chk.sv
module fwdo_chk #(
  parameter int QUEUE_DEPTH = fwdo_pkg::DEPTH_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic [fwdo_pkg::STAT_W-1:0] out_status,
  input logic [fwdo_pkg::TAG_W-1:0]  out_head_tag,
  input logic [fwdo_pkg::TIME_W-1:0] out_head_deadline,
  input logic                        out_expired,
  input logic [fwdo_pkg::OCC_W-1:0]  out_occupancy
);
  import fwdo_pkg::*;

  // One item in work at a time: input closes right after an accept
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in work");

  // Failed operations carry no head entry
  a_no_head_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |->
      (out_head_tag == '0 && out_head_deadline == '0 && !out_expired))
    else $error("head fields set on a failed operation");

  // Empty report leaves the queue empty
  a_empty_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_EMPTY) |-> (out_occupancy == '0))
    else $error("empty status with nonzero occupancy");

  // Full report only at full occupancy
  a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_FULL) |-> (out_occupancy == OCC_W'(QUEUE_DEPTH)))
    else $error("full status below depth");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_EMPTY ||
                   out_status == STAT_FULL))
    else $error("undefined status code");

endmodule

bind fifo_with_deadline_override_top fwdo_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fwdo_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_head_tag      (out_head_tag),
  .out_head_deadline (out_head_deadline),
  .out_expired       (out_expired),
  .out_occupancy     (out_occupancy)
);

### tb/tb_fifo_with_deadline_override_top.sv
module tb_fifo_with_deadline_override_top;
  import fwdo_pkg::*;

  localparam int            DEPTH       = DEPTH_DEF;
  localparam int            ITEMS_TOTAL = 1250;
  localparam int            IDLE_LIMIT  = 5000;
  localparam int            REPORT_MAX  = 10;
  localparam logic [62:0]   TIME_MAX    = '1;

  typedef struct {
    status_t         status;
    logic [TAG_W-1:0]  head_tag;
    logic [TIME_W-1:0] head_deadline;
    logic            expired;
    logic [OCC_W-1:0]  occupancy;
  } queue_result_t;

  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  // Mirror of the deadline queue plus the results it still owes
  class deadline_queue_model;
    logic [TAG_W-1:0]  held_tags[DEPTH];
    logic [TIME_W-1:0] held_deadlines[DEPTH];
    int                held_count;
    queue_result_t     owed_results[$];
    int                fail_count;

    function new();
      held_count = 0;
      fail_count = 0;
    endfunction

    // Apply one accepted item and queue the result it must produce
    function void note_item(op_t op, logic [TAG_W-1:0] tag, logic [TIME_W-1:0] deadline,
                            logic [TIME_W-1:0] now_t);
      queue_result_t     r;
      int                slot;
      int                min_slot;
      logic [TIME_W-1:0] min_deadline;
      r.status        = STAT_OK;
      r.head_tag      = '0;
      r.head_deadline = '0;
      r.expired       = 1'b0;
      case (op)
        OP_PUSH: begin
          if (held_count >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            held_tags[held_count]      = tag;
            held_deadlines[held_count] = deadline;
            held_count++;
          end
        end
        OP_POP, OP_PEEK: begin
          if (held_count == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            // earliest slot wins a tie on the smallest deadline
            min_slot     = 0;
            min_deadline = held_deadlines[0];
            for (int i = 1; i < held_count; i++) begin
              if (held_deadlines[i] < min_deadline) begin
                min_deadline = held_deadlines[i];
                min_slot     = i;
              end
            end
            slot      = (min_deadline < now_t) ? min_slot : 0;
            r.expired = (min_deadline < now_t);
            r.head_tag      = held_tags[slot];
            r.head_deadline = held_deadlines[slot];
            if (op == OP_POP) begin
              // close the gap, keep arrival order
              for (int i = slot; i + 1 < held_count; i++) begin
                held_tags[i]      = held_tags[i + 1];
                held_deadlines[i] = held_deadlines[i + 1];
              end
              held_count--;
            end
          end
        end
        default: ;
      endcase
      r.occupancy = held_count[OCC_W-1:0];
      owed_results = {owed_results, r};
    endfunction

    // Compare one delivered result with the oldest owed one
    function void check_result(queue_result_t got);
      queue_result_t want;
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("result with nothing owed: status %0d tag %h", got.status, got.head_tag);
        return;
      end
      want = owed_results[0];
      owed_results.delete(0);
      if (got.status !== want.status || got.head_tag !== want.head_tag ||
          got.head_deadline !== want.head_deadline || got.expired !== want.expired ||
          got.occupancy !== want.occupancy) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("mismatch: status %0d/%0d tag %h/%h deadline %h/%h expired %b/%b occ %0d/%0d",
                   want.status, got.status, want.head_tag, got.head_tag,
                   want.head_deadline, got.head_deadline, want.expired, got.expired,
                   want.occupancy, got.occupancy);
        end
      end
    endfunction
  endclass

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_opcode   = '0;
  logic [TAG_W-1:0]    in_tag      = '0;
  logic [TIME_W-1:0]   in_deadline = '0;
  logic [TIME_W-1:0]   in_now      = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [TAG_W-1:0]    out_head_tag;
  logic [TIME_W-1:0]   out_head_deadline;
  logic                out_expired;
  logic [OCC_W-1:0]    out_occupancy;

  deadline_queue_model queue_model = new();
  int                  items_sent  = 0;
  int                  burst_left  = 1;
  int                  idle_cycles = 0;
  int                  rx_cycle    = 0;
  rx_mode_t            rx_mode     = RX_FREE;
  logic [TIME_W-1:0]   time_base   = 63'd1000;

  fifo_with_deadline_override_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_tag           (in_tag),
    .in_deadline      (in_deadline),
    .in_now           (in_now),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_head_tag     (out_head_tag),
    .out_head_deadline(out_head_deadline),
    .out_expired      (out_expired),
    .out_occupancy    (out_occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern, in a mode redrawn at random from free, light, heavy and periodic
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
      default:  out_stall <= ((rx_cycle % 11) < 6);
    endcase
  end

  // Watch both channels: predict, check, and bound the time without progress
  always @(posedge clk) begin
    queue_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall)
        queue_model.note_item(op_t'(in_opcode), in_tag, in_deadline, in_now);
      if (out_valid && !out_stall) begin
        got.status        = status_t'(out_status);
        got.head_tag      = out_head_tag;
        got.head_deadline = out_head_deadline;
        got.expired       = out_expired;
        got.occupancy     = out_occupancy;
        queue_model.check_result(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  // Mostly close to the running base so deadlines straddle the current time
  function automatic logic [TIME_W-1:0] near_time();
    case ($urandom_range(0, 31))
      0:       return '0;
      1:       return TIME_MAX;
      2:       return rand_time();
      default: return time_base - 63'd16 + 63'($urandom_range(0, 31));
    endcase
  endfunction

  // Offer one item, hold it until taken, then maybe open a gap
  task automatic send_item(op_t op, logic [TAG_W-1:0] tag, logic [TIME_W-1:0] deadline,
                           logic [TIME_W-1:0] now_t);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_tag      <= tag;
    in_deadline <= deadline;
    in_now      <= now_t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  initial begin
    int   roll;
    int   run_len;
    op_t  op;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queue, unused opcode, extremes, ties, expiry choices
    send_item(OP_POP,  16'h0000, '0, TIME_MAX);
    send_item(OP_PEEK, 16'hFFFF, TIME_MAX, '0);
    send_item(OP_NOP,  16'hFFFF, TIME_MAX, TIME_MAX);
    send_item(OP_PUSH, 16'hFFFF, TIME_MAX, '0);
    send_item(OP_PUSH, 16'h0000, '0, TIME_MAX);
    send_item(OP_PUSH, 16'h1234, '0, '0);
    send_item(OP_PEEK, 16'h0000, '0, '0);
    send_item(OP_PEEK, 16'h0000, '0, 63'd1);
    send_item(OP_POP,  16'h0000, '0, TIME_MAX);
    send_item(OP_POP,  16'h0000, '0, 63'd1);
    send_item(OP_NOP,  16'h5A5A, 63'd7, 63'd7);
    send_item(OP_POP,  16'h0000, '0, TIME_MAX);
    send_item(OP_PUSH, 16'h00A1, 63'd100, '0);
    send_item(OP_PUSH, 16'h00B2, 63'd200, '0);
    send_item(OP_POP,  16'h0000, '0, 63'd100);
    send_item(OP_PUSH, 16'h00C3, 63'd50, '0);
    send_item(OP_POP,  16'h0000, '0, 63'd150);
    send_item(OP_POP,  16'h0000, '0, 63'd300);
    send_item(OP_PEEK, 16'h0000, '0, TIME_MAX);

    // Random runs: fill past full, drain past empty, mixed traffic, noise
    while (items_sent < ITEMS_TOTAL) begin
      roll = $urandom_range(0, 9);
      if (roll < 2) begin
        repeat (DEPTH + $urandom_range(1, 3))
          send_item(OP_PUSH, 16'($urandom), near_time(), near_time());
      end else if (roll < 3) begin
        repeat (DEPTH + $urandom_range(1, 3))
          send_item(op_t'(($urandom_range(0, 3) == 0) ? OP_PEEK : OP_POP), 16'($urandom),
                    near_time(), near_time());
      end else if (roll < 8) begin
        run_len = $urandom_range(4, 24);
        repeat (run_len) begin
          roll = $urandom_range(0, 99);
          if (roll < 45)      op = OP_PUSH;
          else if (roll < 75) op = OP_POP;
          else if (roll < 95) op = OP_PEEK;
          else                op = OP_NOP;
          send_item(op, 16'($urandom), near_time(), near_time());
        end
        time_base = time_base + 63'($urandom_range(0, 12));
      end else if (roll < 9) begin
        repeat ($urandom_range(3, 10))
          send_item(op_t'($urandom_range(0, 3)), 16'($urandom), rand_time(), rand_time());
      end else begin
        // move the time base, keeping clear of wraparound
        time_base = rand_time();
        if (time_base < 63'd1000)           time_base = time_base + 63'd1000;
        if (time_base > TIME_MAX - 63'd1000) time_base = time_base - 63'd1000;
      end
    end

    // Drain outstanding results, then allow for the slowest operation
    in_valid <= 1'b0;
    while (queue_model.owed_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 20) @(posedge clk);

    if (queue_model.fail_count == 0 && queue_model.owed_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### fifo_with_deadline_override_top.f
rtl/fwdo_pkg.sv
rtl/fwdo_ctrl.sv
rtl/fwdo_dp.sv
rtl/fifo_with_deadline_override_top.sv
rtl/fwdo_chk.sv
tb/tb_fifo_with_deadline_override_top.sv
